FILE: rtl/slcq_pkg.sv
// Shared types, widths and constants for the shaded line clip and quad setup block.
// Used by slcq_clip and shaded_line_clip_and_quad_setup; depends on nothing.
package slcq_pkg;

    // Number formats
    localparam int COORD_INT_BITS  = 12;
    localparam int COORD_FRAC_BITS = 4;
    localparam int COLOR_BITS      = 8;
    localparam int COORD_BITS      = COORD_INT_BITS + COORD_FRAC_BITS;
    localparam int WIDE_BITS       = COORD_BITS + 1;
    localparam int DIV_BITS        = WIDE_BITS + 1;
    localparam int PIX_BITS        = COORD_INT_BITS + 1;
    localparam int RATIO_BITS      = 16;
    localparam int PROD_BITS       = 2 * WIDE_BITS;

    // Divider: quotient bits resolved per pipeline stage
    localparam int DIV_STAGES = 4;
    localparam int DIV_STEPS  = RATIO_BITS / DIV_STAGES;

    // Eight clip steps: x low/high for each end, then y
    localparam int CLIP_COUNT = 8;

    // Stream and config port widths
    localparam int IN_BITS        = 4 * COORD_BITS + 8 * COLOR_BITS;
    localparam int IN_DATA_BITS   = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS       = 2 * COORD_INT_BITS + 4 * COLOR_BITS;
    localparam int OUT_DATA_BITS  = ((OUT_BITS + 7) / 8) * 8;
    localparam int REG_BITS       = 11;
    localparam int CFG_INDEX_BITS = 2;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [WIDE_BITS-1:0]  wide_t;
    typedef logic signed [PIX_BITS-1:0]   pix_t;
    typedef logic [COLOR_BITS-1:0]        color_t;
    typedef color_t [3:0]                 rgba_t;    // [0] red .. [3] alpha
    typedef logic [RATIO_BITS-1:0]        ratio_t;
    typedef logic [REG_BITS-1:0]          reg_val_t;
    typedef logic [CFG_INDEX_BITS-1:0]    cfg_index_t;

    // One line in flight
    typedef struct packed {
        coord_t x0;
        coord_t y0;
        coord_t x1;
        coord_t y1;
        rgba_t  c0;
        rgba_t  c1;
        logic   alive;      // cleared when the line is rejected
        logic   clip_en;    // some coordinate lies off screen
    } line_t;

    // Which clip a clip stage performs
    typedef struct packed {
        logic axis_y;   // clip against y (else x)
        logic end1;     // moves the end point (else the start point)
        logic high;     // against the limit (else against zero)
        logic first;    // first clip of the axis: also does the reject test
    } clip_mode_t;

    typedef enum logic [2:0] {
        OCT_0, OCT_1, OCT_2, OCT_3, OCT_4, OCT_5, OCT_6, OCT_7
    } octant_t;

    localparam ratio_t     RATIO_MAX   = '1;    // just under 1.0
    localparam logic [2:0] FLIP_X      = 3'd3;
    localparam logic [2:0] FLIP_Y      = 3'd7;
    localparam logic [2:0] FLIP_STEEP  = 3'd1;

    localparam cfg_index_t CFG_SCREEN_WIDTH  = 2'd0;
    localparam cfg_index_t CFG_SCREEN_HEIGHT = 2'd1;
    localparam reg_val_t   WIDTH_RESET       = 11'd640;
    localparam reg_val_t   HEIGHT_RESET      = 11'd480;

endpackage

FILE: rtl/slcq_clip.sv
// One clip step of the line pipeline: reject test, ratio division and interpolation.
// Seven register stages; depends on slcq_pkg.
module slcq_clip
    import slcq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       adv,
    input  clip_mode_t mode,
    input  wide_t      lim,
    input  logic       in_valid,
    input  line_t      in_line,
    output logic       out_valid,
    output line_t      out_line
);

    typedef struct packed {
        coord_t p;      // clipped axis, moved point
        coord_t q;      // clipped axis, kept point
        coord_t om;     // other axis, moved point
        coord_t okc;    // other axis, kept point
        rgba_t  cm;
        rgba_t  ck;
    } canon_t;

    typedef struct packed {
        line_t                line;
        logic                 act;
        logic                 zero;
        logic                 sat;
        logic [WIDE_BITS-1:0] den;
        logic [WIDE_BITS-1:0] rem;
        ratio_t               quo;
    } dv_t;

    typedef struct packed {
        line_t                       line;
        logic                        act;
        logic signed [PROD_BITS-1:0] pc;
        logic signed [PROD_BITS-1:0] pr;
        logic signed [PROD_BITS-1:0] pg;
        logic signed [PROD_BITS-1:0] pb;
        logic signed [PROD_BITS-1:0] pa;
    } ml_t;

    // Map the line onto moved/kept terms for this clip
    function automatic canon_t canon_of(line_t l, clip_mode_t m);
        canon_t c;
        coord_t a0, a1, b0, b1;
        a0 = m.axis_y ? l.y0 : l.x0;
        a1 = m.axis_y ? l.y1 : l.x1;
        b0 = m.axis_y ? l.x0 : l.y0;
        b1 = m.axis_y ? l.x1 : l.y1;
        c.p   = m.end1 ? a1 : a0;
        c.q   = m.end1 ? a0 : a1;
        c.om  = m.end1 ? b1 : b0;
        c.okc = m.end1 ? b0 : b1;
        c.cm  = m.end1 ? l.c1 : l.c0;
        c.ck  = m.end1 ? l.c0 : l.c1;
        return c;
    endfunction

    // Store the moved point back into the line
    function automatic line_t put_back(line_t l, clip_mode_t m, coord_t p, coord_t om,
                                       rgba_t cm);
        line_t r;
        coord_t nx, ny;
        r  = l;
        nx = m.axis_y ? om : p;
        ny = m.axis_y ? p : om;
        if (m.end1)
        begin
            r.x1 = nx;
            r.y1 = ny;
            r.c1 = cm;
        end
        else
        begin
            r.x0 = nx;
            r.y0 = ny;
            r.c0 = cm;
        end
        return r;
    endfunction

    // Product over 65536, truncated toward zero
    function automatic wide_t trunc_ratio(logic signed [PROD_BITS-1:0] v);
        logic signed [PROD_BITS-1:0] t;
        logic signed [PROD_BITS-1:0] s;
        t = v;
        if (v < 0)
            t = v + PROD_BITS'((1 << RATIO_BITS) - 1);
        s = t >>> RATIO_BITS;
        return s[WIDE_BITS-1:0];
    endfunction

    dv_t  dv_reg [0:DIV_STAGES];
    dv_t  dv_next [0:DIV_STAGES];
    dv_t  dv0_next;
    logic dv_v_reg [0:DIV_STAGES];
    ml_t  ml_reg;
    ml_t  ml_next;
    logic ml_v_reg;
    line_t fin_reg;
    line_t fin_next;
    logic  fin_v_reg;

    // Setup: reject test, clip condition, normalized ratio operands
    always_comb
    begin
        canon_t c;
        coord_t a0, a1;
        logic drop, cond, live;
        logic signed [DIV_BITS-1:0] num_raw, den_raw, num_n, den_n;
        c  = canon_of(in_line, mode);
        a0 = mode.axis_y ? in_line.y0 : in_line.x0;
        a1 = mode.axis_y ? in_line.y1 : in_line.x1;
        drop = mode.first && ((a0 <= 0 && a1 <= 0) ||
                              (wide_t'(a0) >= lim && wide_t'(a1) >= lim));
        cond = mode.high ? (wide_t'(c.p) > lim) : (c.p < 0);
        live = in_line.alive && in_line.clip_en && !drop;
        num_raw = mode.high ? (DIV_BITS'(c.q) - DIV_BITS'(lim)) : DIV_BITS'(c.q);
        den_raw = DIV_BITS'(c.q) - DIV_BITS'(c.p);
        if (den_raw < 0)
        begin
            num_n = -num_raw;
            den_n = -den_raw;
        end
        else
        begin
            num_n = num_raw;
            den_n = den_raw;
        end
        dv0_next.line       = in_line;
        dv0_next.line.alive = in_line.alive && !(in_line.clip_en && drop);
        dv0_next.act        = live && cond;
        dv0_next.zero       = (den_n == 0) || (num_n <= 0);
        dv0_next.sat        = !dv0_next.zero && (num_n >= den_n);
        dv0_next.den        = den_n[WIDE_BITS-1:0];
        dv0_next.rem        = (dv0_next.zero || dv0_next.sat) ? '0
                              : num_n[WIDE_BITS-1:0];
        dv0_next.quo        = '0;
    end

    // Restoring division, DIV_STEPS quotient bits per stage
    always_comb
    begin
        logic [WIDE_BITS:0] r2;
        dv_next[0] = dv0_next;
        for (int i = 1; i <= DIV_STAGES; i++)
        begin
            dv_next[i] = dv_reg[i-1];
            for (int s = 0; s < DIV_STEPS; s++)
            begin
                r2 = {dv_next[i].rem, 1'b0};
                if (r2 >= {1'b0, dv_next[i].den})
                begin
                    r2 = r2 - {1'b0, dv_next[i].den};
                    dv_next[i].quo = {dv_next[i].quo[RATIO_BITS-2:0], 1'b1};
                end
                else
                begin
                    dv_next[i].quo = {dv_next[i].quo[RATIO_BITS-2:0], 1'b0};
                end
                dv_next[i].rem = r2[WIDE_BITS-1:0];
            end
        end
    end

    // Ratio select and the five products
    always_comb
    begin
        canon_t c;
        ratio_t r;
        wide_t  rs;
        wide_t  d0, d1, d2, d3, d4;
        c  = canon_of(dv_reg[DIV_STAGES].line, mode);
        r  = dv_reg[DIV_STAGES].zero ? '0
             : (dv_reg[DIV_STAGES].sat ? RATIO_MAX : dv_reg[DIV_STAGES].quo);
        rs = wide_t'(r);
        d0 = wide_t'(c.okc) - wide_t'(c.om);
        d1 = wide_t'(c.ck[0]) - wide_t'(c.cm[0]);
        d2 = wide_t'(c.ck[1]) - wide_t'(c.cm[1]);
        d3 = wide_t'(c.ck[2]) - wide_t'(c.cm[2]);
        d4 = wide_t'(c.ck[3]) - wide_t'(c.cm[3]);
        ml_next.line = dv_reg[DIV_STAGES].line;
        ml_next.act  = dv_reg[DIV_STAGES].act;
        ml_next.pc   = rs * d0;
        ml_next.pr   = rs * d1;
        ml_next.pg   = rs * d2;
        ml_next.pb   = rs * d3;
        ml_next.pa   = rs * d4;
    end

    // Interpolate and move the point onto the edge
    always_comb
    begin
        canon_t c;
        wide_t  nv, n0, n1, n2, n3;
        rgba_t  cm;
        coord_t p;
        c  = canon_of(ml_reg.line, mode);
        nv = wide_t'(c.okc) - trunc_ratio(ml_reg.pc);
        n0 = wide_t'(c.ck[0]) - trunc_ratio(ml_reg.pr);
        n1 = wide_t'(c.ck[1]) - trunc_ratio(ml_reg.pg);
        n2 = wide_t'(c.ck[2]) - trunc_ratio(ml_reg.pb);
        n3 = wide_t'(c.ck[3]) - trunc_ratio(ml_reg.pa);
        cm[0] = n0[COLOR_BITS-1:0];
        cm[1] = n1[COLOR_BITS-1:0];
        cm[2] = n2[COLOR_BITS-1:0];
        cm[3] = n3[COLOR_BITS-1:0];
        p  = mode.high ? lim[COORD_BITS-1:0] : '0;
        if (ml_reg.act)
            fin_next = put_back(ml_reg.line, mode, p, nv[COORD_BITS-1:0], cm);
        else
            fin_next = ml_reg.line;
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= DIV_STAGES; i++)
                dv_v_reg[i] <= 1'b0;
            ml_v_reg  <= 1'b0;
            fin_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            dv_v_reg[0] <= in_valid;
            for (int i = 1; i <= DIV_STAGES; i++)
                dv_v_reg[i] <= dv_v_reg[i-1];
            ml_v_reg  <= dv_v_reg[DIV_STAGES];
            fin_v_reg <= ml_v_reg;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i <= DIV_STAGES; i++)
                dv_reg[i] <= dv_next[i];
            ml_reg  <= ml_next;
            fin_reg <= fin_next;
        end
    end

    assign out_valid = fin_v_reg;
    assign out_line  = fin_reg;

endmodule

FILE: rtl/shaded_line_clip_and_quad_setup.sv
// The four vertices of a line follow one per output handshake; the next line loads as the
// last vertex is taken, and a rejected line sends no vertex. Input reg, eight 7-stage
// clip units, octant stage, then the output holding register.
// Reset clears every valid bit and the output counter; screen size resets to 640 x 480.
// Top level of the shaded line clip and quad setup block.
// Depends on slcq_pkg and slcq_clip.
module shaded_line_clip_and_quad_setup
    import slcq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // start_x, start_y, end_x, end_y, start_red/green/blue/alpha, end_red/green/blue/alpha
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [IN_DATA_BITS-1:0]  s_tdata,
    // vertex_x, vertex_y, vertex_red, vertex_green, vertex_blue, vertex_alpha
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [OUT_DATA_BITS-1:0] m_tdata,
    output logic                     m_tlast,    // last_vertex
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  cfg_index_t               cfg_index,
    input  reg_val_t                 cfg_data
);

    typedef struct packed {
        pix_t    ax;
        pix_t    ay;
        pix_t    bx;
        pix_t    by;
        octant_t quad;
        rgba_t   c0;
        rgba_t   c1;
        logic    alive;
    } cv_t;

    localparam pix_t PIX_ONE = 1;

    // Fixed point to integer, truncated toward zero
    function automatic pix_t pix_of(coord_t v);
        logic signed [COORD_BITS:0] t;
        logic signed [COORD_BITS:0] s;
        t = {v[COORD_BITS-1], v};
        if (v < 0)
            t = t + (COORD_BITS+1)'((1 << COORD_FRAC_BITS) - 1);
        s = t >>> COORD_FRAC_BITS;
        return s[PIX_BITS-1:0];
    endfunction

    reg_val_t width_reg;
    reg_val_t height_reg;
    wide_t    w_fx;
    wide_t    h_fx;

    logic  adv;
    logic  in_v_reg;
    line_t in_reg;
    line_t in_next;

    logic  chain_v [0:CLIP_COUNT];
    line_t chain_line [0:CLIP_COUNT];

    logic cv_valid_reg;
    cv_t  cv_reg;
    cv_t  cv_next;

    logic  ov_reg;
    logic [1:0] out_cnt_reg;
    logic [COORD_INT_BITS-1:0] vx_reg [0:3];
    logic [COORD_INT_BITS-1:0] vy_reg [0:3];
    logic [COORD_INT_BITS-1:0] vx_next [0:3];
    logic [COORD_INT_BITS-1:0] vy_next [0:3];
    rgba_t oc0_reg;
    rgba_t oc1_reg;
    logic  take;
    logic  load_ok;
    logic  load;
    rgba_t out_col;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                CFG_SCREEN_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign w_fx = wide_t'(width_reg) << COORD_FRAC_BITS;
    assign h_fx = wide_t'(height_reg) << COORD_FRAC_BITS;

    // Input register: unpack and flag off-screen lines
    always_comb
    begin
        in_next.x0    = s_tdata[0 +: COORD_BITS];
        in_next.y0    = s_tdata[COORD_BITS +: COORD_BITS];
        in_next.x1    = s_tdata[2*COORD_BITS +: COORD_BITS];
        in_next.y1    = s_tdata[3*COORD_BITS +: COORD_BITS];
        in_next.c0    = s_tdata[4*COORD_BITS +: 4*COLOR_BITS];
        in_next.c1    = s_tdata[4*COORD_BITS + 4*COLOR_BITS +: 4*COLOR_BITS];
        in_next.alive = 1'b1;
        in_next.clip_en = (in_next.x0 < 0) || (in_next.x1 < 0) ||
                          (in_next.y0 < 0) || (in_next.y1 < 0) ||
                          (wide_t'(in_next.x0) >= w_fx) || (wide_t'(in_next.x1) >= w_fx) ||
                          (wide_t'(in_next.y0) >= h_fx) || (wide_t'(in_next.y1) >= h_fx);
    end

    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_v_reg <= 1'b0;
        else if (adv)
            in_v_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            in_reg <= in_next;
    end

    assign chain_v[0]    = in_v_reg;
    assign chain_line[0] = in_reg;

    // Clip chain: x against zero and width, then y against zero and height
    for (genvar g = 0; g < CLIP_COUNT; g++)
    begin : g_clip
        localparam clip_mode_t MODE = '{axis_y: (g >= 4), end1: ((g % 2) == 1),
                                        high: ((g % 4) >= 2), first: ((g % 4) == 0)};
        wide_t lim;
        assign lim = (g >= 4) ? h_fx : w_fx;

        slcq_clip u_clip (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .mode      (MODE),
            .lim       (lim),
            .in_valid  (chain_v[g]),
            .in_line   (chain_line[g]),
            .out_valid (chain_v[g+1]),
            .out_line  (chain_line[g+1])
        );
    end

    // Integer endpoints and octant
    always_comb
    begin
        line_t l;
        pix_t  dx, dy;
        logic [2:0] q;
        l = chain_line[CLIP_COUNT];
        cv_next.ax = pix_of(l.x0);
        cv_next.ay = pix_of(l.y0);
        cv_next.bx = pix_of(l.x1);
        cv_next.by = pix_of(l.y1);
        dx = cv_next.bx - cv_next.ax;
        dy = cv_next.ay - cv_next.by;
        q  = 3'd0;
        if (cv_next.bx < cv_next.ax)
        begin
            q  = q ^ FLIP_X;
            dx = -dx;
        end
        if (cv_next.by > cv_next.ay)
        begin
            q  = q ^ FLIP_Y;
            dy = -dy;
        end
        if (dx < dy)
            q = q ^ FLIP_STEEP;
        cv_next.quad  = octant_t'(q);
        cv_next.c0    = l.c0;
        cv_next.c1    = l.c1;
        cv_next.alive = l.alive;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cv_valid_reg <= 1'b0;
        else if (adv)
            cv_valid_reg <= chain_v[CLIP_COUNT];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            cv_reg <= cv_next;
    end

    // Quad corners for the octant
    always_comb
    begin
        pix_t ax, ay, bx, by;
        pix_t vx [0:3];
        pix_t vy [0:3];
        ax = cv_reg.ax;
        ay = cv_reg.ay;
        bx = cv_reg.bx;
        by = cv_reg.by;
        case (cv_reg.quad)
            OCT_0:
            begin
                if (by < PIX_ONE) by = PIX_ONE;
                vx[0] = ax;           vy[0] = ay;
                vx[1] = ax;           vy[1] = ay + PIX_ONE;
                vx[2] = bx + PIX_ONE; vy[2] = by;
                vx[3] = bx + PIX_ONE; vy[3] = by - PIX_ONE;
            end
            OCT_1:
            begin
                if (ax < PIX_ONE) ax = PIX_ONE;
                vx[0] = ax - PIX_ONE; vy[0] = ay + PIX_ONE;
                vx[1] = ax;           vy[1] = ay + PIX_ONE;
                vx[2] = bx + PIX_ONE; vy[2] = by;
                vx[3] = bx;           vy[3] = by;
            end
            OCT_2:
            begin
                vx[0] = ax;           vy[0] = ay + PIX_ONE;
                vx[1] = ax + PIX_ONE; vy[1] = ay + PIX_ONE;
                vx[2] = bx + PIX_ONE; vy[2] = by;
                vx[3] = bx;           vy[3] = by;
            end
            OCT_3:
            begin
                if (by < PIX_ONE) by = PIX_ONE;
                vx[0] = ax + PIX_ONE; vy[0] = ay;
                vx[1] = ax + PIX_ONE; vy[1] = ay + PIX_ONE;
                vx[2] = bx;           vy[2] = by;
                vx[3] = bx;           vy[3] = by - PIX_ONE;
            end
            OCT_4:
            begin
                if (ay < PIX_ONE) ay = PIX_ONE;
                vx[0] = ax + PIX_ONE; vy[0] = ay - PIX_ONE;
                vx[1] = ax + PIX_ONE; vy[1] = ay;
                vx[2] = bx;           vy[2] = by + PIX_ONE;
                vx[3] = bx;           vy[3] = by;
            end
            OCT_5:
            begin
                if (bx < PIX_ONE) bx = PIX_ONE;
                vx[0] = ax;           vy[0] = ay;
                vx[1] = ax + PIX_ONE; vy[1] = ay;
                vx[2] = bx;           vy[2] = by + PIX_ONE;
                vx[3] = bx - PIX_ONE; vy[3] = by + PIX_ONE;
            end
            OCT_6:
            begin
                vx[0] = ax;           vy[0] = ay;
                vx[1] = ax + PIX_ONE; vy[1] = ay;
                vx[2] = bx + PIX_ONE; vy[2] = by + PIX_ONE;
                vx[3] = bx;           vy[3] = by + PIX_ONE;
            end
            default:
            begin
                // octant 7
                if (ay < PIX_ONE) ay = PIX_ONE;
                vx[0] = ax;           vy[0] = ay - PIX_ONE;
                vx[1] = ax;           vy[1] = ay;
                vx[2] = bx + PIX_ONE; vy[2] = by + PIX_ONE;
                vx[3] = bx + PIX_ONE; vy[3] = by;
            end
        endcase
        for (int k = 0; k < 4; k++)
        begin
            vx_next[k] = vx[k][COORD_INT_BITS-1:0];
            vy_next[k] = vy[k][COORD_INT_BITS-1:0];
        end
    end

    // Output holding register, one vertex per transaction
    assign take    = ov_reg && m_tready;
    assign load_ok = !ov_reg || (take && out_cnt_reg == 2'd3);
    assign adv     = !cv_valid_reg || !cv_reg.alive || load_ok;
    assign load    = cv_valid_reg && cv_reg.alive && load_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg      <= 1'b0;
            out_cnt_reg <= 2'd0;
        end
        else if (load)
        begin
            ov_reg      <= 1'b1;
            out_cnt_reg <= 2'd0;
        end
        else if (take)
        begin
            ov_reg      <= (out_cnt_reg != 2'd3);
            out_cnt_reg <= out_cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int k = 0; k < 4; k++)
            begin
                vx_reg[k] <= vx_next[k];
                vy_reg[k] <= vy_next[k];
            end
            oc0_reg <= cv_reg.c0;
            oc1_reg <= cv_reg.c1;
        end
    end

    assign out_col  = out_cnt_reg[1] ? oc1_reg : oc0_reg;
    assign m_tvalid = ov_reg;
    assign m_tlast  = (out_cnt_reg == 2'd3);
    assign m_tdata  = OUT_DATA_BITS'({out_col, vy_reg[out_cnt_reg], vx_reg[out_cnt_reg]});

    // A partly sent quad always has its holding register occupied
    a_cnt_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_cnt_reg != 2'd0 |-> ov_reg)
        else $error("vertex counter advanced without a quad held");

    // Input back-pressure only comes from a live line waiting on a busy output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> cv_valid_reg && cv_reg.alive && ov_reg)
        else $error("pipeline stalled without a blocked output");

    // A loaded quad starts at its first vertex
    a_load_start: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> ov_reg && out_cnt_reg == 2'd0)
        else $error("quad load did not restart the vertex counter");

endmodule
